// File: rtl/mrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

  localparam int TBL_DEPTH = 4;

  typedef logic [2:0] op_t;
  typedef logic [2:0] port_t;
  typedef logic [1:0] vc_t;
  typedef logic [1:0] cnt_t;
  typedef logic [3:0] coord_t;

  localparam op_t OP_HEAD  = 3'd0;
  localparam op_t OP_BODY  = 3'd1;
  localparam op_t OP_TAIL  = 3'd2;
  localparam op_t OP_PORTQ = 3'd3;
  localparam op_t OP_VCQ   = 3'd4;

  localparam logic [2:0] ALG_XY   = 3'd0;
  localparam logic [2:0] ALG_NF   = 3'd1;
  localparam logic [2:0] ALG_WF   = 3'd2;
  localparam logic [2:0] ALG_NL   = 3'd3;
  localparam logic [2:0] ALG_OE   = 3'd4;
  localparam logic [2:0] ALG_NMNL = 3'd5;

  localparam port_t PORT_LOCAL = 3'd0;
  localparam port_t PORT_W     = 3'd1;
  localparam port_t PORT_E     = 3'd2;
  localparam port_t PORT_YM    = 3'd3;
  localparam port_t PORT_YP    = 3'd4;

  localparam logic [2:0] REG_ALG  = 3'd0;
  localparam logic [2:0] REG_MYX  = 3'd1;
  localparam logic [2:0] REG_MYY  = 3'd2;
  localparam logic [2:0] REG_COLS = 3'd3;
  localparam logic [2:0] REG_ROWS = 3'd4;

  typedef struct packed {
    logic [2:0] alg;
    coord_t     my_x;
    coord_t     my_y;
    logic [4:0] cols;
    logic [4:0] rows;
  } cfg_t;

  typedef struct packed {
    op_t    op;
    vc_t    vc;
    coord_t dest_x;
    coord_t dest_y;
    coord_t src_x;
    port_t  in_port;
  } req_t;

  // ports[2:0] is the first candidate
  typedef struct packed {
    logic [8:0] ports;
    cnt_t       count;
  } route_t;

  typedef struct packed {
    logic  all_idle;
    logic  error;
    logic  live;
    vc_t   out_vc;
    cnt_t  count;
    port_t egress;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/mesh_route_computation_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A request accepted into the request register passes through the route logic and the
// channel table into the result register, which drives out_tdata; out_tready low holds it.
// Throughput: one request per cycle unless out_tready is low; route logic and the
// channel table sit between the request and result registers, so nothing iterates.
// Reset (rst_n low, synchronous): all channels invalid, pointers zero, algorithm XY,
// router at (0,0), mesh 4 x 4, both pipeline registers empty.
module mesh_route_computation_top #(
  parameter int VC_COUNT = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // vc_index[1:0], dest_x[5:2], dest_y[9:6], src_x[13:10], in_port[16:14]
  input  wire  [23:0] in_tdata,
  // operation[2:0]
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // egress port[2:0], candidate_count[4:3], out_vc[6:5], live route[7], error[8],
  // all_idle[9]
  output logic [15:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [4:0]  cfg_wdata
);
  import mrc_pkg::*;

  cfg_t   cfg_r;
  req_t   req_r;
  logic   req_vld_r;
  res_t   res_r;
  logic   res_vld_r;
  route_t route;
  res_t   res;
  logic   advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alg  <= ALG_XY;
      cfg_r.my_x <= '0;
      cfg_r.my_y <= '0;
      cfg_r.cols <= 5'd4;
      cfg_r.rows <= 5'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALG:  cfg_r.alg  <= cfg_wdata[2:0];
        REG_MYX:  cfg_r.my_x <= cfg_wdata[3:0];
        REG_MYY:  cfg_r.my_y <= cfg_wdata[3:0];
        REG_COLS: cfg_r.cols <= cfg_wdata;
        REG_ROWS: cfg_r.rows <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // advance the held request into the result register when it is free
  assign advance   = req_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !req_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_tready) req_vld_r <= in_tvalid;
      if (advance) res_vld_r <= 1'b1;
      else if (out_tready) res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.op      <= in_tuser;
      req_r.vc      <= in_tdata[1:0];
      req_r.dest_x  <= in_tdata[5:2];
      req_r.dest_y  <= in_tdata[9:6];
      req_r.src_x   <= in_tdata[13:10];
      req_r.in_port <= in_tdata[16:14];
    end
    if (advance) res_r <= res;
  end

  mrc_route u_route (
    .cfg   (cfg_r),
    .req   (req_r),
    .route (route)
  );

  mrc_table #(
    .VC_COUNT (VC_COUNT)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .req   (req_r),
    .route (route),
    .res   (res)
  );

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {6'd0, res_r};

endmodule

`default_nettype wire

// File: rtl/mrc_route.sv
`timescale 1ns / 1ps
`default_nettype none

module mrc_route (
  input  wire mrc_pkg::cfg_t cfg,
  input  wire mrc_pkg::req_t req,
  output mrc_pkg::route_t    route
);
  import mrc_pkg::*;

  function automatic route_t add_port(route_t r, port_t p);
    route_t o;
    o = r;
    case (r.count)
      2'd0: begin o.ports[2:0] = p; o.count = 2'd1; end
      2'd1: begin o.ports[5:3] = p; o.count = 2'd2; end
      2'd2: begin o.ports[8:6] = p; o.count = 2'd3; end
      default: o = r;
    endcase
    return o;
  endfunction

  logic xn, xz, xp, yn, yz, yp;
  logic x_one, fringe;
  port_t xy;
  route_t r;

  assign xn = req.dest_x < cfg.my_x;
  assign xz = req.dest_x == cfg.my_x;
  assign xp = req.dest_x > cfg.my_x;
  assign yn = req.dest_y < cfg.my_y;
  assign yz = req.dest_y == cfg.my_y;
  assign yp = req.dest_y > cfg.my_y;
  assign x_one = {1'b0, req.dest_x} == ({1'b0, cfg.my_x} + 5'd1);
  assign fringe = (cfg.my_x == 4'd0) || (cfg.my_y == 4'd0) ||
                  (({1'b0, cfg.my_x} + 5'd1) >= cfg.cols) ||
                  (({1'b0, cfg.my_y} + 5'd1) >= cfg.rows);

  always_comb begin
    if (xz && yz)  xy = PORT_LOCAL;
    else if (xz)   xy = yn ? PORT_YM : PORT_YP;
    else           xy = xn ? PORT_W : PORT_E;
  end

  always_comb begin
    r = '0;
    if (xz && yz) begin
      r = add_port(r, PORT_LOCAL);
    end else begin
      case (cfg.alg)
        ALG_NF: begin
          if (xn && yn) begin
            r = add_port(r, PORT_W);
            r = add_port(r, PORT_YM);
          end else if (xn) r = add_port(r, PORT_W);
          else if (yn) r = add_port(r, PORT_YM);
          else if (xp && yp) begin
            r = add_port(r, PORT_E);
            r = add_port(r, PORT_YP);
          end else if (xz) r = add_port(r, PORT_YP);
          else r = add_port(r, PORT_E);
        end
        ALG_WF: begin
          if (xn) r = add_port(r, PORT_W);
          else if (xp) begin
            r = add_port(r, PORT_E);
            if (yn) r = add_port(r, PORT_YM);
            else if (yp) r = add_port(r, PORT_YP);
          end else r = add_port(r, yn ? PORT_YM : PORT_YP);
        end
        ALG_NL: begin
          if (xn) begin
            r = add_port(r, PORT_W);
            if (yp) r = add_port(r, PORT_YP);
          end else if (xp) begin
            if (yp) begin
              r = add_port(r, PORT_YP);
              r = add_port(r, PORT_E);
            end else r = add_port(r, PORT_E);
          end else r = add_port(r, yn ? PORT_YM : PORT_YP);
        end
        ALG_OE: begin
          if (xz) r = add_port(r, yp ? PORT_YP : PORT_YM);
          else if (xp) begin
            if (yz) r = add_port(r, PORT_E);
            else begin
              if (cfg.my_x[0] || (cfg.my_x == req.src_x))
                r = add_port(r, yp ? PORT_YP : PORT_YM);
              if (req.dest_x[0] || !x_one) r = add_port(r, PORT_E);
            end
          end else begin
            r = add_port(r, PORT_W);
            if (!cfg.my_x[0] && !yz) r = add_port(r, yp ? PORT_YP : PORT_YM);
          end
        end
        ALG_NMNL: begin
          if (fringe) r = add_port(r, xy);
          else if (req.in_port == PORT_YP) r = add_port(r, PORT_YM);
          else if (!xz || yp) begin
            if (req.in_port != PORT_W) r = add_port(r, PORT_W);
            if (req.in_port != PORT_E) r = add_port(r, PORT_E);
            r = add_port(r, PORT_YP);
          end else r = add_port(r, PORT_YM);
        end
        default: r = add_port(r, xy);
      endcase
    end
    // fall back to XY when nothing was chosen
    if (r.count == 2'd0) r = add_port(r, xy);
  end

  assign route = r;

endmodule

`default_nettype wire

// File: rtl/mrc_table.sv
`timescale 1ns / 1ps
`default_nettype none

module mrc_table #(
  parameter int VC_COUNT = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire mrc_pkg::req_t   req,
  input  wire mrc_pkg::route_t route,
  output mrc_pkg::res_t        res
);
  import mrc_pkg::*;

  logic [TBL_DEPTH-1:0] valid_r, valid_nxt;
  logic [8:0]           ports_r [TBL_DEPTH];
  cnt_t                 count_r [TBL_DEPTH];
  cnt_t                 count_nxt [TBL_DEPTH];
  cnt_t                 pptr_r [TBL_DEPTH];
  cnt_t                 pptr_nxt [TBL_DEPTH];
  vc_t                  vptr_r [TBL_DEPTH];
  vc_t                  vptr_nxt [TBL_DEPTH];

  logic       exists;
  logic [1:0] p;
  logic [2:0] vsum;
  logic       wr_ports;

  assign exists = int'(req.vc) < VC_COUNT;
  assign vsum   = {1'b0, vptr_r[req.vc]} + 3'd1;

  always_comb begin
    p = pptr_r[req.vc];
    if (p >= count_r[req.vc]) p = 2'd0;
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    pptr_nxt  = pptr_r;
    vptr_nxt  = vptr_r;
    wr_ports  = 1'b0;
    res       = '0;
    if (!exists) begin
      if (req.op inside {[OP_HEAD:OP_VCQ]}) res.error = 1'b1;
    end else if (req.op == OP_HEAD) begin
      wr_ports            = 1'b1;
      count_nxt[req.vc]   = route.count;
      pptr_nxt[req.vc]    = 2'd0;
      valid_nxt[req.vc]   = 1'b1;
      res.egress          = route.ports[2:0];
    end else if ((req.op inside {[OP_BODY:OP_VCQ]}) && !valid_r[req.vc]) begin
      res.error = 1'b1;
    end else if (req.op == OP_TAIL) begin
      valid_nxt[req.vc] = 1'b0;
      count_nxt[req.vc] = 2'd0;
      pptr_nxt[req.vc]  = 2'd0;
    end else if (req.op == OP_PORTQ) begin
      case (p)
        2'd0:    res.egress = ports_r[req.vc][2:0];
        2'd1:    res.egress = ports_r[req.vc][5:3];
        2'd2:    res.egress = ports_r[req.vc][8:6];
        default: res.egress = PORT_LOCAL;
      endcase
      pptr_nxt[req.vc] = p + 2'd1;
    end else if (req.op == OP_VCQ) begin
      res.out_vc = vptr_r[req.vc];
      // wrap at VC_COUNT; the pointer itself keeps two bits
      vptr_nxt[req.vc] = (int'(vsum) >= VC_COUNT) ? 2'd0 : vsum[1:0];
    end
    res.count    = exists ? count_nxt[req.vc] : 2'd0;
    res.live     = exists ? valid_nxt[req.vc] : 1'b0;
    res.all_idle = ~|valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        count_r[i] <= '0;
        pptr_r[i]  <= '0;
        vptr_r[i]  <= '0;
      end
    end else if (en) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        count_r[i] <= count_nxt[i];
        pptr_r[i]  <= pptr_nxt[i];
        vptr_r[i]  <= vptr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr_ports) ports_r[req.vc] <= route.ports;
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mrc_pkg::*;

  localparam int CHANNELS    = 4;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 91;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 1000;

  // operation codes the block treats as no-ops
  localparam op_t OP_UNUSED_LO = 3'd5;
  localparam op_t OP_UNUSED_HI = 3'd7;

  class route_scoreboard;
    logic [2:0] alg;
    coord_t     my_x, my_y;
    logic [4:0] cols, rows;
    int         channels;
    bit         valid[TBL_DEPTH];
    logic [8:0] ports[TBL_DEPTH];
    int         cand_count[TBL_DEPTH];
    int         port_ptr[TBL_DEPTH];
    int         vc_ptr[TBL_DEPTH];
    port_t      cand[3];
    int         cand_n;
    res_t       pending_results[$];
    int         fail_count, checked, requests, heads, flagged;

    function new(int n_vc);
      channels = n_vc;
      alg = ALG_XY;
      my_x = '0;
      my_y = '0;
      cols = 5'd4;
      rows = 5'd4;
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        ports[i] = '0;
        cand_count[i] = 0;
        port_ptr[i] = 0;
        vc_ptr[i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [4:0] v);
      case (idx)
        REG_ALG:  alg = v[2:0];
        REG_MYX:  my_x = v[3:0];
        REG_MYY:  my_y = v[3:0];
        REG_COLS: cols = v;
        REG_ROWS: rows = v;
        default: ;
      endcase
    endfunction

    function void add_cand(port_t p);
      if (cand_n < 3) begin
        cand[cand_n] = p;
        cand_n++;
      end
    endfunction

    function port_t xy_port(int dx, int dy);
      if (dx == 0 && dy == 0) return PORT_LOCAL;
      if (dx == 0) return dy < 0 ? PORT_YM : PORT_YP;
      return dx < 0 ? PORT_W : PORT_E;
    endfunction

    function port_t y_port(int dy);
      return dy > 0 ? PORT_YP : PORT_YM;
    endfunction

    // ordered candidate list for a head flit under the current setting
    function void plan_route(req_t r);
      int dx, dy, cx, cy;
      bit fringe;
      cx = my_x;
      cy = my_y;
      dx = int'(r.dest_x) - cx;
      dy = int'(r.dest_y) - cy;
      cand_n = 0;
      cand = '{PORT_LOCAL, PORT_LOCAL, PORT_LOCAL};
      if (alg != ALG_NMNL && dx == 0 && dy == 0) begin
        add_cand(PORT_LOCAL);
        return;
      end
      case (alg)
        ALG_NF: begin
          if (dx < 0 && dy < 0) begin
            add_cand(PORT_W);
            add_cand(PORT_YM);
          end else if (dx < 0) begin
            add_cand(PORT_W);
          end else if (dy < 0) begin
            add_cand(PORT_YM);
          end else if (dx > 0 && dy > 0) begin
            add_cand(PORT_E);
            add_cand(PORT_YP);
          end else if (dx == 0) begin
            add_cand(PORT_YP);
          end else begin
            add_cand(PORT_E);
          end
        end
        ALG_WF: begin
          if (dx < 0) begin
            add_cand(PORT_W);
          end else if (dx > 0) begin
            add_cand(PORT_E);
            if (dy != 0) add_cand(y_port(dy));
          end else begin
            add_cand(y_port(dy));
          end
        end
        ALG_NL: begin
          if (dx < 0) begin
            add_cand(PORT_W);
            if (dy > 0) add_cand(PORT_YP);
          end else if (dx > 0) begin
            if (dy > 0) add_cand(PORT_YP);
            add_cand(PORT_E);
          end else begin
            add_cand(y_port(dy));
          end
        end
        ALG_OE: begin
          if (dx == 0) begin
            add_cand(y_port(dy));
          end else if (dx > 0) begin
            if (dy == 0) begin
              add_cand(PORT_E);
            end else begin
              if ((cx % 2) != 0 || cx == int'(r.src_x)) add_cand(y_port(dy));
              if (r.dest_x[0] || dx != 1) add_cand(PORT_E);
            end
          end else begin
            add_cand(PORT_W);
            if ((cx % 2) == 0 && dy != 0) add_cand(y_port(dy));
          end
        end
        ALG_NMNL: begin
          fringe = cx == 0 || cy == 0 || cx + 1 >= int'(cols) || cy + 1 >= int'(rows);
          if (fringe) begin
            add_cand(xy_port(dx, dy));
          end else if (dx == 0 && dy == 0) begin
            add_cand(PORT_LOCAL);
          end else if (r.in_port == PORT_YP) begin
            add_cand(PORT_YM);
          end else if (dx != 0 || dy > 0) begin
            if (r.in_port != PORT_W) add_cand(PORT_W);
            if (r.in_port != PORT_E) add_cand(PORT_E);
            add_cand(PORT_YP);
          end else begin
            add_cand(PORT_YM);
          end
        end
        default: add_cand(xy_port(dx, dy));
      endcase
      if (cand_n == 0) add_cand(xy_port(dx, dy));
    endfunction

    function void note_request(req_t r);
      res_t e;
      int ch, p, i;
      bit busy;
      e = '0;
      ch = r.vc;
      requests++;
      if (ch >= channels) begin
        if (r.op <= OP_VCQ) e.error = 1'b1;
      end else if (r.op == OP_HEAD) begin
        plan_route(r);
        ports[ch] = {cand[2], cand[1], cand[0]};
        cand_count[ch] = cand_n;
        port_ptr[ch] = 0;
        valid[ch] = 1'b1;
        e.egress = cand[0];
        heads++;
      end else if (r.op <= OP_VCQ && !valid[ch]) begin
        e.error = 1'b1;
      end else if (r.op == OP_TAIL) begin
        valid[ch] = 1'b0;
        cand_count[ch] = 0;
        port_ptr[ch] = 0;
      end else if (r.op == OP_PORTQ) begin
        p = port_ptr[ch];
        if (p >= cand_count[ch]) p = 0;
        e.egress = ports[ch][3*p +: 3];
        port_ptr[ch] = (p + 1) & 3;
      end else if (r.op == OP_VCQ) begin
        e.out_vc = vc_t'(vc_ptr[ch]);
        vc_ptr[ch] = (vc_ptr[ch] + 1) % channels;
      end
      busy = 1'b0;
      for (i = 0; i < TBL_DEPTH && i < channels; i++)
        if (valid[i]) busy = 1'b1;
      if (ch < channels) begin
        e.count = cnt_t'(cand_count[ch]);
        e.live = valid[ch];
      end
      e.all_idle = !busy;
      if (e.error) flagged++;
      pending_results = {pending_results, e};
    endfunction

    task report(string what, int got, int want);
      fail_count++;
      if (fail_count <= 40)
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, checked);
    endtask

    task check_result(res_t got);
      res_t w;
      if (pending_results.size() == 0) begin
        report("result with no request pending", int'(got), 0);
        return;
      end
      w = pending_results.pop_front();
      checked++;
      if (got.egress !== w.egress) report("egress port", got.egress, w.egress);
      if (got.count !== w.count) report("candidate_count", got.count, w.count);
      if (got.out_vc !== w.out_vc) report("out_vc", got.out_vc, w.out_vc);
      if (got.live !== w.live)
        report("live route flag", got.live, w.live);
      if (got.error !== w.error) report("error", got.error, w.error);
      if (got.all_idle !== w.all_idle) report("all_idle", got.all_idle, w.all_idle);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [4:0]  cfg_wdata;

  route_scoreboard sb;
  int burst_left  = 0;
  int rx_cycle    = 0;
  int rx_mode     = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  mesh_route_computation_top #(.VC_COUNT(CHANNELS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // receiver back-pressure: periodically switches among four out_tready patterns
  always @(negedge clk) begin
    if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_cycle % 8) < 3;
      default: out_tready <= $urandom_range(0, 4) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(res_t'(out_tdata[9:0]));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("mesh_route_computation_top regression: fail");
      $finish;
    end
  end

  // hold the request until accepted; sender runs in bursts with random gaps
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) >= 3) ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.in_port, r.src_x, r.dest_y, r.dest_x, r.vc};
    in_tuser  <= r.op;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic req_t dreq(op_t op, vc_t vc, coord_t dx, coord_t dy, coord_t sx,
                                port_t ip);
    req_t r;
    r.op = op;
    r.vc = vc;
    r.dest_x = dx;
    r.dest_y = dy;
    r.src_x = sx;
    r.in_port = ip;
    return r;
  endfunction

  // bias destinations towards this router so zero and unit offsets occur often
  function automatic coord_t near(coord_t mine);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return mine;
    if (roll < 38) return mine + 4'd1;
    if (roll < 50) return mine - 4'd1;
    return coord_t'($urandom_range(0, 15));
  endfunction

  function automatic req_t random_req();
    req_t r;
    int roll;
    r.vc = vc_t'($urandom_range(0, CHANNELS - 1));
    r.dest_x = near(sb.my_x);
    r.dest_y = near(sb.my_y);
    r.src_x = $urandom_range(0, 1) ? sb.my_x : coord_t'($urandom_range(0, 15));
    r.in_port = ($urandom_range(0, 99) < 85) ? port_t'($urandom_range(0, 4)) :
                                               port_t'($urandom_range(5, 7));
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      r.op = op_t'($urandom_range(OP_HEAD, OP_UNUSED_HI));
    end else if (!sb.valid[r.vc]) begin
      r.op = OP_HEAD;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) r.op = OP_HEAD;
      else if (roll < 35) r.op = OP_PORTQ;
      else if (roll < 60) r.op = OP_VCQ;
      else if (roll < 80) r.op = OP_BODY;
      else r.op = OP_TAIL;
    end
    return r;
  endfunction

  task automatic pick_extreme(output logic [4:0] v);
    case ($urandom_range(0, 3))
      0: v = 5'd1;
      1: v = 5'd16;
      2: v = 5'd0;
      default: v = 5'd31;
    endcase
  endtask

  task automatic apply_setting(input int k);
    int x, y;
    logic [4:0] c, rw;
    case (k % 3)
      0: begin
        x = (k & 1) ? 15 : 0;
        y = (k & 2) ? 15 : 0;
        pick_extreme(c);
        pick_extreme(rw);
      end
      1: begin
        // interior router, so non-minimal north-last leaves its fallback
        x = $urandom_range(1, 13);
        y = $urandom_range(1, 13);
        c = 5'($urandom_range(x + 2, 16));
        rw = 5'($urandom_range(y + 2, 16));
      end
      default: begin
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        c = 5'($urandom_range(0, 31));
        rw = 5'($urandom_range(0, 31));
      end
    endcase
    write_reg(REG_ALG, 5'(k % 8));
    write_reg(REG_MYX, 5'(x));
    write_reg(REG_MYY, 5'(y));
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, rw);
  endtask

  task automatic run_directed();
    send_request(dreq(OP_PORTQ, 2'd0, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_VCQ, 2'd3, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_BODY, 2'd1, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd2, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_HEAD, 2'd0, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_HEAD, 2'd1, 4'd15, 4'd15, 4'd15, PORT_YP));
    send_request(dreq(OP_HEAD, 2'd2, 4'd0, 4'd15, 4'd0, 3'd7));
    send_request(dreq(OP_HEAD, 2'd3, 4'd15, 4'd0, 4'd10, PORT_YM));
    repeat (2) send_request(dreq(OP_PORTQ, 2'd1, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    // walk past the last output channel to check the wrap
    repeat (5) send_request(dreq(OP_VCQ, 2'd1, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_BODY, 2'd2, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_HEAD, 2'd1, 4'd0, 4'd0, 4'd5, PORT_E));
    send_request(dreq(OP_PORTQ, 2'd1, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_UNUSED_LO, 2'd0, 4'd15, 4'd15, 4'd15, PORT_YP));
    send_request(dreq(OP_UNUSED_HI, 2'd3, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd0, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd1, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd2, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd3, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
    send_request(dreq(OP_TAIL, 2'd3, 4'd0, 4'd0, 4'd0, PORT_LOCAL));
  endtask

  initial begin
    int k, i;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    sb = new(CHANNELS);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (k = 0; k < PHASES; k++) begin
      if (k > 0) apply_setting(k);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until the pipeline is empty
        if (i == PHASE_ITEMS / 2) drain();
        send_request(random_req());
      end
      drain();
    end

    if (sb.pending_results.size() != 0)
      sb.report("results never delivered", 0, sb.pending_results.size());
    $display("run covered %0d requests (%0d head flits, %0d flagged as errors) over %0d",
             sb.requests, sb.heads, sb.flagged, PHASES);
    $display("router settings with all algorithm codes; %0d results checked, %0d mismatches",
             sb.checked, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("mesh_route_computation_top regression: pass");
    end else begin
      $display("mesh_route_computation_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mrc_pkg.sv
rtl/mrc_route.sv
rtl/mrc_table.sv
rtl/mesh_route_computation_top.sv
test/tb_top.sv
